// ===== rtl/aavr_pkg.sv =====
// Shared constants and arithmetic helpers for the axis-angle vector rotator.
package aavr_pkg;

    localparam int unsigned    ANGLE_W      = 16;
    localparam int unsigned    AXIS_W       = 16;
    localparam int unsigned    VEC_W        = 32;
    localparam logic [33:0]    DEG_TO_RAD_K = 34'd9595049034;   // pi/23040 * 2^46
    localparam logic [31:0]    Q30_ONE      = 32'd1073741824;
    localparam int             QUARTER_TURN = 11520;            // 90 deg in Q.7
    localparam int             HALF_TURN    = 23040;            // 180 deg in Q.7
    localparam int unsigned    SIN_STEPS    = 6;
    localparam int unsigned    COS_STEPS    = 7;
    localparam int unsigned    SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned    COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};

    // shift right with rounding half away from zero
    function automatic logic signed [79:0] rnd_shift(input logic signed [79:0] v,
                                                     input int unsigned sh);
        logic [79:0] mag;
        mag = v[79] ? 80'(-v) : 80'(v);
        mag = (mag + (80'(1) << (sh - 1))) >> sh;
        return v[79] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/aavr_delay.sv =====
// Enable-gated delay line for side data that rides alongside the pipeline.
module aavr_delay #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

// ===== rtl/aavr_horner_step.sv =====
// One Horner step t' = 1 - round(round(x2*t)/K), four register stages.
module aavr_horner_step #(
    parameter int unsigned K = 2
) (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        x2_in,
    input  logic signed [31:0] t_in,
    output logic [31:0]        x2_out,
    output logic signed [31:0] t_out
);

    localparam logic [40:0] RECIP = 41'((64'd1 << 40) / K);
    localparam logic [32:0] HALF_K = 33'(K / 2);
    localparam logic signed [34:0] Q30_ONE_S = 35'(aavr_pkg::Q30_ONE);

    logic signed [64:0] p_reg;
    logic [32:0]        n_reg, n2_reg, q0_reg;
    logic               neg_reg, neg2_reg;
    logic [31:0]        x2a_reg, x2b_reg, x2c_reg, x2d_reg;
    logic signed [31:0] t_reg;

    logic [64:0]        mag;
    logic [34:0]        m;
    logic [73:0]        prod;
    logic [39:0]        qk, rem;
    logic [32:0]        q;
    logic signed [34:0] t_next;

    always_comb
    begin
        mag  = p_reg[64] ? 65'(-p_reg) : 65'(p_reg);
        m    = 35'((mag + 65'(1 << 29)) >> 30);
        prod = 74'(n_reg) * 74'(RECIP);
        qk   = 40'(q0_reg) * 40'(K);
        rem  = 40'(n2_reg) - qk;
        q    = q0_reg + 33'(rem >= 40'(K));
        t_next = Q30_ONE_S - (neg2_reg ? -$signed({2'b00, q}) : $signed({2'b00, q}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= $signed({1'b0, x2_in}) * 65'(t_in);
            x2a_reg  <= x2_in;
            n_reg    <= m[32:0] + HALF_K;
            neg_reg  <= p_reg[64];
            x2b_reg  <= x2a_reg;
            q0_reg   <= prod[72:40];
            n2_reg   <= n_reg;
            neg2_reg <= neg_reg;
            x2c_reg  <= x2b_reg;
            t_reg    <= t_next[31:0];
            x2d_reg  <= x2c_reg;
        end
    end

    // neg2 carries the product sign alongside q0 into the final correction stage
    assign x2_out = x2d_reg;
    assign t_out  = t_reg;

endmodule

// ===== rtl/axis_angle_vector_rotation.sv =====
// Throughput: one word per cycle; the 41-stage pipeline advances whenever the output
// register is empty or being taken, so a stall freezes every stage and loses nothing.
// Cost per word is set by the two Horner chains (sine 6 steps, cosine 7 steps, 4 stages each).
// Reset (rst_n, asynchronous, active low) clears the valid bits only; the datapath
// registers are not reset and carry no meaning until a valid word reaches them.
module axis_angle_vector_rotation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] angle_deg,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    localparam int unsigned LAT = 41;

    // Global advance: every stage moves together, output register is the last stage.
    logic adv;
    logic [LAT-1:0] vld_reg;

    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // ---- E1: half angle range reduction (angle read as Q.7 = half angle) ----
    logic signed [16:0] h, hr;
    logic               flip;
    logic [13:0]        a_reg;
    logic               flip_reg, neg_reg;

    always_comb
    begin
        h    = 17'(angle_deg);
        hr   = h;
        flip = 1'b0;
        if (h > 17'(aavr_pkg::QUARTER_TURN))
        begin
            hr   = h - 17'(aavr_pkg::HALF_TURN);
            flip = 1'b1;
        end
        else if (h < -17'(aavr_pkg::QUARTER_TURN))
        begin
            hr   = h + 17'(aavr_pkg::HALF_TURN);
            flip = 1'b1;
        end
    end

    // ---- E2..E5: degrees to radians in Q30, then x^2 ----
    logic [47:0] ak_reg;
    logic [30:0] r_reg;
    logic [61:0] rr_reg;
    logic [31:0] x2_reg;
    logic [47:0] ak_rnd;
    logic [61:0] rr_rnd;

    assign ak_rnd = ak_reg + 48'(1 << 15);
    assign rr_rnd = rr_reg + 62'(1 << 29);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= hr[16] ? 14'(-hr) : hr[13:0];
            flip_reg <= flip;
            neg_reg  <= hr[16];
            ak_reg   <= 48'(a_reg) * 48'(aavr_pkg::DEG_TO_RAD_K);
            r_reg    <= ak_rnd[46:16];
            rr_reg   <= 62'(r_reg) * 62'(r_reg);
            x2_reg   <= rr_rnd[61:30];
        end
    end

    // ---- E6..E29 / E6..E33: Horner chains for sine and cosine ----
    logic [31:0]        sin_x2 [aavr_pkg::SIN_STEPS+1];
    logic signed [31:0] sin_t  [aavr_pkg::SIN_STEPS+1];
    logic [31:0]        cos_x2 [aavr_pkg::COS_STEPS+1];
    logic signed [31:0] cos_t  [aavr_pkg::COS_STEPS+1];

    assign sin_x2[0] = x2_reg;
    assign sin_t[0]  = $signed(aavr_pkg::Q30_ONE);
    assign cos_x2[0] = x2_reg;
    assign cos_t[0]  = $signed(aavr_pkg::Q30_ONE);

    for (genvar i = 0; i < aavr_pkg::SIN_STEPS; i++)
    begin : g_sin
        aavr_horner_step #(.K(aavr_pkg::SIN_DIV[i])) u_step (
            .clk    (clk),
            .en     (adv),
            .x2_in  (sin_x2[i]),
            .t_in   (sin_t[i]),
            .x2_out (sin_x2[i+1]),
            .t_out  (sin_t[i+1])
        );
    end

    for (genvar i = 0; i < aavr_pkg::COS_STEPS; i++)
    begin : g_cos
        aavr_horner_step #(.K(aavr_pkg::COS_DIV[i])) u_step (
            .clk    (clk),
            .en     (adv),
            .x2_in  (cos_x2[i]),
            .t_in   (cos_t[i]),
            .x2_out (cos_x2[i+1]),
            .t_out  (cos_t[i+1])
        );
    end

    // side data alignment
    logic [30:0] r_d;
    logic [1:0]  sgn_d;
    logic [30:0] smag_d;
    logic [47:0] axis_d;
    logic [95:0] vec_d;

    aavr_delay #(.WIDTH(31), .DEPTH(26)) u_r_dly (
        .clk(clk), .en(adv), .din(r_reg), .dout(r_d));
    aavr_delay #(.WIDTH(2), .DEPTH(32)) u_sgn_dly (
        .clk(clk), .en(adv), .din({flip_reg, neg_reg}), .dout(sgn_d));
    aavr_delay #(.WIDTH(48), .DEPTH(34)) u_axis_dly (
        .clk(clk), .en(adv), .din({axis_x, axis_y, axis_z}), .dout(axis_d));
    aavr_delay #(.WIDTH(96), .DEPTH(36)) u_vec_dly (
        .clk(clk), .en(adv), .din({vec_x, vec_y, vec_z}), .dout(vec_d));

    // ---- E30, E31: sine = clamp(round(r * t)) ----
    logic signed [63:0] sp_reg;
    logic [30:0]        smag_reg;
    logic signed [79:0] sp_rnd;

    assign sp_rnd = aavr_pkg::rnd_shift(80'(sp_reg), 30);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sp_reg <= $signed({33'b0, r_d}) * 64'(sin_t[aavr_pkg::SIN_STEPS]);
            if (sp_rnd < 0)
                smag_reg <= '0;
            else if (sp_rnd > 80'(aavr_pkg::Q30_ONE))
                smag_reg <= 31'(aavr_pkg::Q30_ONE);
            else
                smag_reg <= sp_rnd[30:0];
        end
    end

    aavr_delay #(.WIDTH(31), .DEPTH(2)) u_s_dly (
        .clk(clk), .en(adv), .din(smag_reg), .dout(smag_d));

    // ---- E34: clamp cosine, apply quadrant signs ----
    logic signed [31:0] s_reg, c_reg;
    logic signed [31:0] tc;
    logic [30:0]        cmag;

    assign tc = cos_t[aavr_pkg::COS_STEPS];

    always_comb
    begin
        if (tc < 0)
            cmag = '0;
        else if (tc > $signed(aavr_pkg::Q30_ONE))
            cmag = 31'(aavr_pkg::Q30_ONE);
        else
            cmag = tc[30:0];
    end

    // ---- E35, E36: quaternion in Q28 ----
    logic signed [47:0] pax_reg, pay_reg, paz_reg;
    logic signed [31:0] c2_reg;
    logic signed [30:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [79:0] qx_r, qy_r, qz_r, qw_r;

    assign qx_r = aavr_pkg::rnd_shift(80'(pax_reg), 16);
    assign qy_r = aavr_pkg::rnd_shift(80'(pay_reg), 16);
    assign qz_r = aavr_pkg::rnd_shift(80'(paz_reg), 16);
    assign qw_r = aavr_pkg::rnd_shift(80'(c2_reg), 2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg   <= (sgn_d[1] != sgn_d[0]) ? -$signed({1'b0, smag_d})
                                              : $signed({1'b0, smag_d});
            c_reg   <= sgn_d[1] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
            pax_reg <= 48'($signed(axis_d[47:32])) * 48'(s_reg);
            pay_reg <= 48'($signed(axis_d[31:16])) * 48'(s_reg);
            paz_reg <= 48'($signed(axis_d[15:0]))  * 48'(s_reg);
            c2_reg  <= c_reg;
            qx_reg  <= qx_r[30:0];
            qy_reg  <= qy_r[30:0];
            qz_reg  <= qz_r[30:0];
            qw_reg  <= qw_r[30:0];
        end
    end

    // ---- E37, E38: t = q * v ----
    logic signed [31:0] vx, vy, vz;
    logic signed [62:0] pa_reg [12];
    logic signed [37:0] ra [12];
    logic signed [37:0] tw_reg, tx_reg, ty_reg, tz_reg;
    logic signed [79:0] ra_full [12];

    assign vx = vec_d[95:64];
    assign vy = vec_d[63:32];
    assign vz = vec_d[31:0];

    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            ra_full[i] = aavr_pkg::rnd_shift(80'(pa_reg[i]), 28);
            ra[i]      = ra_full[i][37:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg[0]  <= 63'(qx_reg) * 63'(vx);
            pa_reg[1]  <= 63'(qy_reg) * 63'(vy);
            pa_reg[2]  <= 63'(qz_reg) * 63'(vz);
            pa_reg[3]  <= 63'(qw_reg) * 63'(vx);
            pa_reg[4]  <= 63'(qy_reg) * 63'(vz);
            pa_reg[5]  <= 63'(qz_reg) * 63'(vy);
            pa_reg[6]  <= 63'(qw_reg) * 63'(vy);
            pa_reg[7]  <= 63'(qz_reg) * 63'(vx);
            pa_reg[8]  <= 63'(qx_reg) * 63'(vz);
            pa_reg[9]  <= 63'(qw_reg) * 63'(vz);
            pa_reg[10] <= 63'(qx_reg) * 63'(vy);
            pa_reg[11] <= 63'(qy_reg) * 63'(vx);
            tw_reg <= -ra[0] - ra[1] - ra[2];
            tx_reg <= ra[3] + ra[4] - ra[5];
            ty_reg <= ra[6] + ra[7] - ra[8];
            tz_reg <= ra[9] + ra[10] - ra[11];
        end
    end

    // q held two more stages to meet t
    logic [123:0]       q_d;
    logic signed [30:0] qxd, qyd, qzd, qwd;

    aavr_delay #(.WIDTH(124), .DEPTH(2)) u_q_dly (
        .clk(clk), .en(adv), .din({qx_reg, qy_reg, qz_reg, qw_reg}), .dout(q_d));

    assign qxd = q_d[123:93];
    assign qyd = q_d[92:62];
    assign qzd = q_d[61:31];
    assign qwd = q_d[30:0];

    // ---- E39..E41: r = t * conj(q), then saturate ----
    logic signed [68:0] pb_reg [12];
    logic signed [43:0] rb_reg [12];
    logic signed [79:0] rb_full [12];
    logic signed [47:0] rx, ry, rz;

    always_comb
    begin
        for (int i = 0; i < 12; i++)
        begin
            rb_full[i] = aavr_pkg::rnd_shift(80'(pb_reg[i]), 28);
        end
        rx = 48'(rb_reg[0]) - 48'(rb_reg[1]) - 48'(rb_reg[2]) + 48'(rb_reg[3]);
        ry = 48'(rb_reg[4]) - 48'(rb_reg[5]) - 48'(rb_reg[6]) + 48'(rb_reg[7]);
        rz = 48'(rb_reg[8]) - 48'(rb_reg[9]) - 48'(rb_reg[10]) + 48'(rb_reg[11]);
    end

    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pb_reg[0]  <= 69'(tx_reg) * 69'(qwd);
            pb_reg[1]  <= 69'(tw_reg) * 69'(qxd);
            pb_reg[2]  <= 69'(ty_reg) * 69'(qzd);
            pb_reg[3]  <= 69'(tz_reg) * 69'(qyd);
            pb_reg[4]  <= 69'(ty_reg) * 69'(qwd);
            pb_reg[5]  <= 69'(tw_reg) * 69'(qyd);
            pb_reg[6]  <= 69'(tz_reg) * 69'(qxd);
            pb_reg[7]  <= 69'(tx_reg) * 69'(qzd);
            pb_reg[8]  <= 69'(tz_reg) * 69'(qwd);
            pb_reg[9]  <= 69'(tw_reg) * 69'(qzd);
            pb_reg[10] <= 69'(tx_reg) * 69'(qyd);
            pb_reg[11] <= 69'(ty_reg) * 69'(qxd);
            for (int i = 0; i < 12; i++)
            begin
                rb_reg[i] <= rb_full[i][43:0];
            end
            out_x_reg <= aavr_pkg::sat32(rx);
            out_y_reg <= aavr_pkg::sat32(ry);
            out_z_reg <= aavr_pkg::sat32(rz);
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign out_z = out_z_reg;

    // ---- checks ----
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[LAT-2] && adv) |=> out_valid)
        else $error("word lost before the output register");

    a_sine_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[30] |-> (smag_reg <= 31'(aavr_pkg::Q30_ONE)))
        else $error("sine magnitude beyond one");

endmodule

// ===== dv/aavr_checker.sv =====
// Output checker: predicts rotated vectors from the input channel and compares them.
`timescale 1ns / 100ps
module aavr_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] angle_deg,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    output int                 fail_count,
    output int                 pending,
    output int                 checked
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    vec3_t rotated_q[$];

    function automatic longint rshift_rnd(longint v, int sh);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint mulr(longint a, longint b, int sh);
        return rshift_rnd(a * b, sh);
    endfunction

    function automatic longint div_round(longint v, longint k);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + k / 2) / k;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0) return 0;
        if (v > longint'(aavr_pkg::Q30_ONE)) return longint'(aavr_pkg::Q30_ONE);
        return v;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic vec3_t rotate_vec(longint h, longint ax, longint ay, longint az,
                                         longint vx, longint vy, longint vz);
        bit flip, neg;
        longint a, r, x2, t, s, c, one;
        longint qx, qy, qz, qw, tw, tx, ty, tz;
        vec3_t res;
        one = longint'(aavr_pkg::Q30_ONE);
        flip = 0;
        // fold half angle into +-90 deg, which negates sine and cosine
        if (h > aavr_pkg::QUARTER_TURN)
        begin
            h -= aavr_pkg::HALF_TURN;
            flip = 1;
        end
        else if (h < -aavr_pkg::QUARTER_TURN)
        begin
            h += aavr_pkg::HALF_TURN;
            flip = 1;
        end
        neg = h < 0;
        a = neg ? -h : h;
        r = rshift_rnd(a * longint'(aavr_pkg::DEG_TO_RAD_K), 16);
        x2 = mulr(r, r, 30);
        t = one;
        for (int i = 0; i < aavr_pkg::SIN_STEPS; i++)
            t = one - div_round(mulr(x2, t, 30), aavr_pkg::SIN_DIV[i]);
        s = unit_clamp(mulr(r, t, 30));
        t = one;
        for (int i = 0; i < aavr_pkg::COS_STEPS; i++)
            t = one - div_round(mulr(x2, t, 30), aavr_pkg::COS_DIV[i]);
        c = unit_clamp(t);
        if (neg != flip) s = -s;
        if (flip) c = -c;
        qx = rshift_rnd(ax * s, 16);
        qy = rshift_rnd(ay * s, 16);
        qz = rshift_rnd(az * s, 16);
        qw = rshift_rnd(c, 2);
        tw = -mulr(qx, vx, 28) - mulr(qy, vy, 28) - mulr(qz, vz, 28);
        tx = mulr(qw, vx, 28) + mulr(qy, vz, 28) - mulr(qz, vy, 28);
        ty = mulr(qw, vy, 28) + mulr(qz, vx, 28) - mulr(qx, vz, 28);
        tz = mulr(qw, vz, 28) + mulr(qx, vy, 28) - mulr(qy, vx, 28);
        res.x = clip32(mulr(tx, qw, 28) - mulr(tw, qx, 28) - mulr(ty, qz, 28)
                       + mulr(tz, qy, 28));
        res.y = clip32(mulr(ty, qw, 28) - mulr(tw, qy, 28) - mulr(tz, qx, 28)
                       + mulr(tx, qz, 28));
        res.z = clip32(mulr(tz, qw, 28) - mulr(tw, qz, 28) - mulr(tx, qy, 28)
                       + mulr(ty, qx, 28));
        return res;
    endfunction

    always @(posedge clk)
    begin
        vec3_t want;
        if (rst_n && in_valid && in_ready)
            rotated_q.push_back(rotate_vec(angle_deg, axis_x, axis_y, axis_z,
                                           vec_x, vec_y, vec_z));
        if (rst_n && out_valid && out_ready)
        begin
            checked++;
            if (rotated_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("error: unexpected word x=%0d y=%0d z=%0d", out_x, out_y, out_z);
            end
            else
            begin
                want = rotated_q.pop_front();
                if (want.x !== out_x || want.y !== out_y || want.z !== out_z)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("error: word %0d exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                                 checked, want.x, want.y, want.z, out_x, out_y, out_z);
                end
            end
        end
        pending = rotated_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top: stimulus, idling phases and verdict for the vector rotator.
`timescale 1ns / 100ps
module tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] angle_deg;
    logic signed [15:0] axis_x, axis_y, axis_z;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x, out_y, out_z;
    int                 fail_count, pending, checked;
    int                 idle_pct, stall_pct;  // sender gap and receiver stall odds
    longint             cycles;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     DRAIN_CYCLES = 60;    // pipeline is 41 deep

    axis_angle_vector_rotation dut (.*);

    aavr_checker u_chk (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog: generous bound over the slowest legal run.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
                $display("FAIL axis_angle_vector_rotation");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure per phase.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Present one word; valid held until taken, then dropped only on a gap.
    task automatic send_word(input logic signed [15:0] ang, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az,
                             input logic signed [31:0] vx, input logic signed [31:0] vy,
                             input logic signed [31:0] vz);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        angle_deg <= ang;
        axis_x <= ax; axis_y <= ay; axis_z <= az;
        vec_x <= vx; vec_y <= vy; vec_z <= vz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_axis();
        // mostly unit-ish components, sometimes full range
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(3))
            0: return 32'($urandom);
            1: return 32'(int'($urandom_range(2000000)) - 1000000);
            default: return 32'(int'($urandom_range(20000000)) - 10000000);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        if ($urandom_range(7) == 0) return 16'($urandom);  // beyond +-360 too
        return 16'(int'($urandom_range(46080)) - 23040);
    endfunction

    initial begin
        in_valid = 0;
        angle_deg = 0; axis_x = 0; axis_y = 0; axis_z = 0;
        vec_x = 0; vec_y = 0; vec_z = 0;
        idle_pct = 0; stall_pct = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: quarter/half turns, fold points, angle extremes, zero and huge axes,
        // saturating vectors.
        send_word(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sd65536, 32'sd131072, 32'sd0);
        send_word(16'sd5760, 16'sd0, 16'sd0, 16'sd16384, 32'sd65536, 32'sd0, 32'sd0);
        send_word(16'sd11520, 16'sd0, 16'sd16384, 16'sd0, 32'sd65536, 32'sd65536, 32'sd7);
        send_word(-16'sd11520, 16'sd16384, 16'sd0, 16'sd0, 32'sd1, 32'sd65536, -32'sd65536);
        send_word(16'sd23040, 16'sd9459, 16'sd9459, 16'sd9459, 32'sd100000, -32'sd5, 32'sd3);
        send_word(-16'sd23040, 16'sd0, 16'sd0, 16'sd16384, 32'sd65536, 32'sd65536, 32'sd65536);
        send_word(16'sd23041, 16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd65536, 32'sd0);
        send_word(-16'sd23041, 16'sd0, 16'sd16384, 16'sd0, 32'sd65536, 32'sd0, 32'sd0);
        send_word(16'sh7FFF, 16'sd0, 16'sd0, 16'sd16384, 32'sd65536, 32'sd0, 32'sd0);
        send_word(16'sh8000, 16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd65536);
        send_word(16'sd11521, 16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd65536, 32'sd0);
        send_word(-16'sd11521, 16'sd0, 16'sd16384, 16'sd0, 32'sd0, 32'sd0, 32'sd65536);
        send_word(16'sd3000, 16'sd0, 16'sd0, 16'sd0, 32'sd123456, -32'sd654321, 32'sd99);
        send_word(16'sd5760, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_word(16'sd5760, 16'sh8000, 16'sh8000, 16'sh8000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_word(16'sd1000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(16'sd0, 16'sh8000, 16'sd0, 16'sh7FFF, 32'sh7FFF_FFFF, 32'sd0, -32'sd1);
        send_word(-16'sd1, 16'sd1, -16'sd1, 16'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFF);

        // Random: four idling phases, each with a mix of rates.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < 333; n++)
                send_word(rand_angle(), rand_axis(), rand_axis(), rand_axis(),
                          rand_vec(), rand_vec(), rand_vec());
        end
        in_valid <= 1'b0;
        stall_pct = 0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d rotations: fold points, angles past +-360, zero and",
                 checked);
        $display("oversized axes, saturation, under four sender/receiver idling mixes");
        if (fail_count == 0)
            $display("PASS axis_angle_vector_rotation");
        else
            $display("FAIL axis_angle_vector_rotation");
        $finish;
    end
endmodule
